@@ design/mpct_pkg.sv @@
`timescale 1ns / 1ps
package mpct_pkg;

  localparam int CH_W   = 5;
  localparam int OFF_W  = 14;
  localparam int DATA_W = 32;
  localparam int PIN_W  = 24;
  localparam int GRP_N  = 6;
  localparam int A_W    = 24;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_PIN   = 2'd3;

  localparam logic [DATA_W-1:0] MOD_GPREN = 32'h0400_0000;
  localparam logic [DATA_W-1:0] MOD_MDIS  = 32'h4000_0000;
  localparam int MOD_GPRE_LSB = 16;
  localparam int GPRE_W       = 8;
  localparam int CH_PRE_LSB   = 16;
  localparam int PRE_W        = 2;

  localparam logic [6:0] MODE_MCB    = 7'h50;
  localparam logic [6:0] MODE_OPWMB  = 7'h60;
  localparam logic [6:0] MODE_OPWMCB = 7'h5D;
  localparam logic [6:0] MODE_SAIC   = 7'h02;

  localparam int CTL_ODIS_BIT = 4;
  localparam int CTL_FALL_BIT = 7;
  localparam int CTL_BOTH_BIT = 8;
  localparam int CTL_FEN_BIT  = 17;

  localparam int CH_BASE = 'h20;
  localparam int CH_SPAN = 'h20;

  localparam logic [OFF_W-1:0] OFF_MOD  = 14'h00;
  localparam logic [OFF_W-1:0] OFF_ODIS = 14'h08;
  localparam logic [OFF_W-1:0] OFF_CDIS = 14'h0C;

  localparam logic [4:0] SUB_A   = 5'h00;
  localparam logic [4:0] SUB_B   = 5'h04;
  localparam logic [4:0] SUB_CNT = 5'h08;
  localparam logic [4:0] SUB_CTL = 5'h0C;
  localparam logic [4:0] SUB_FLG = 5'h10;
  localparam logic [4:0] SUB_ALT = 5'h14;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_RD_A, OP_RD_B, OP_RD_CNT, OP_RD_CTL, OP_RD_FLG, OP_RD_ALT,
    OP_RD_MOD, OP_RD_ODIS, OP_RD_CDIS,
    OP_WR_A, OP_WR_B, OP_WR_CTL, OP_WR_FLG, OP_WR_ALT,
    OP_WR_MOD, OP_WR_ODIS, OP_WR_CDIS,
    OP_TICK, OP_PIN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  ch;
    logic [DATA_W-1:0] data;
    logic             lvl;
  } item_t;

endpackage

@@ design/mpct_front.sv @@
`timescale 1ns / 1ps
module mpct_front #(
  parameter int NUM_CHANNELS = 24
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [mpct_pkg::OFF_W-1:0]  offset,
  input  logic [mpct_pkg::DATA_W-1:0] wdata,
  input  logic [mpct_pkg::CH_W-1:0]   pin_channel,
  input  logic                        pin_level,
  input  logic                        q_full,
  output logic                        push,
  output mpct_pkg::item_t             item
);
  import mpct_pkg::*;

  localparam int WIN_END = CH_BASE + NUM_CHANNELS * CH_SPAN;

  logic             in_win;
  logic [OFF_W-6:0] chn;
  logic [4:0]       sub;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign in_win = (offset >= OFF_W'(CH_BASE)) && (offset < OFF_W'(WIN_END));
  assign chn    = offset[OFF_W-1:5] - 1'b1;
  assign sub    = offset[4:0];

  always_comb begin
    item.op   = OP_NONE;
    item.ch   = '0;
    item.data = wdata;
    item.lvl  = pin_level;
    case (req_type)
      REQ_READ: begin
        if (in_win) begin
          item.ch = chn[CH_W-1:0];
          case (sub)
            SUB_A:   item.op = OP_RD_A;
            SUB_B:   item.op = OP_RD_B;
            SUB_CNT: item.op = OP_RD_CNT;
            SUB_CTL: item.op = OP_RD_CTL;
            SUB_FLG: item.op = OP_RD_FLG;
            SUB_ALT: item.op = OP_RD_ALT;
            default: item.op = OP_NONE;
          endcase
        end else begin
          case (offset)
            OFF_MOD:  item.op = OP_RD_MOD;
            OFF_ODIS: item.op = OP_RD_ODIS;
            OFF_CDIS: item.op = OP_RD_CDIS;
            default:  item.op = OP_NONE;
          endcase
        end
      end
      REQ_WRITE: begin
        if (in_win) begin
          item.ch = chn[CH_W-1:0];
          case (sub)
            SUB_A:   item.op = OP_WR_A;
            SUB_B:   item.op = OP_WR_B;
            SUB_CTL: item.op = OP_WR_CTL;
            SUB_FLG: item.op = OP_WR_FLG;
            SUB_ALT: item.op = OP_WR_ALT;
            default: item.op = OP_NONE;
          endcase
        end else begin
          case (offset)
            OFF_MOD:  item.op = OP_WR_MOD;
            OFF_ODIS: item.op = OP_WR_ODIS;
            OFF_CDIS: item.op = OP_WR_CDIS;
            default:  item.op = OP_NONE;
          endcase
        end
      end
      REQ_TICK: item.op = OP_TICK;
      REQ_PIN: begin
        if (pin_channel < CH_W'(NUM_CHANNELS)) begin
          item.op = OP_PIN;
          item.ch = pin_channel;
        end
      end
      default: item.op = OP_NONE;
    endcase
  end

endmodule

@@ design/mpct_queue.sv @@
`timescale 1ns / 1ps
module mpct_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mpct_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output mpct_pkg::item_t head
);
  import mpct_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) (full && !pop) |=> full)
    else $error("queue lost an entry");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> !empty)
    else $error("queue push not retained");

endmodule

@@ design/mpct_back.sv @@
`timescale 1ns / 1ps
module mpct_back #(
  parameter int NUM_CHANNELS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  mpct_pkg::item_t             q_head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mpct_pkg::DATA_W-1:0] rdata,
  output logic [mpct_pkg::PIN_W-1:0]  pwm_pins,
  output logic [mpct_pkg::PIN_W-1:0]  channel_irqs,
  output logic [mpct_pkg::GRP_N-1:0]  group_irqs
);
  import mpct_pkg::*;

  localparam int IDX_W  = $clog2(NUM_CHANNELS);
  localparam int PROD_W = A_W + PRE_W + 1;
  localparam int GM_W   = GPRE_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_MUL1 = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;
  logic [IDX_W-1:0]  idx;
  op_t               cur_op;
  logic [DATA_W-1:0] cur_data;
  logic              cur_lvl;
  logic [DATA_W-1:0] rd_hold;
  logic [PROD_W-1:0] prod1;

  logic [A_W-1:0]    match_a [NUM_CHANNELS];
  logic [A_W-1:0]    match_b [NUM_CHANNELS];
  logic [A_W-1:0]    alt_a [NUM_CHANNELS];
  logic [DATA_W-1:0] chan_control [NUM_CHANNELS];
  logic [DATA_W-1:0] down_count [NUM_CHANNELS];
  logic [1:0]        duty_phase [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] count_running;
  logic [NUM_CHANNELS-1:0] chan_flag;
  logic [NUM_CHANNELS-1:0] pin_out;
  logic [NUM_CHANNELS-1:0] pin_in;
  logic [NUM_CHANNELS-1:0] chan_irq;
  logic [DATA_W-1:0] module_control;
  logic [DATA_W-1:0] output_disable;
  logic [DATA_W-1:0] channel_disable;

  logic [A_W-1:0]    ma, mb, ma_eff, ma0, per, b_c, a_c, pwm_d;
  logic [DATA_W-1:0] ctl, cnt, cnt_dec;
  logic [6:0]        mode, mode0;
  logic              fen, off_drv, cfg_on, last_idx, scan_all, edge_ok;
  logic [PRE_W:0]    pre_m;
  logic [GM_W-1:0]   gpre_m;
  logic [PROD_W+GM_W-1:0] prod_full;
  logic [DATA_W-1:0] reload;
  logic [NUM_CHANNELS-1:0] fen_v, odis_v;
  logic [PIN_W-1:0]  ff24;
  logic [GRP_N-1:0]  grp;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      fen_v[i]  = chan_control[i][CTL_FEN_BIT];
      odis_v[i] = chan_control[i][CTL_ODIS_BIT];
    end
    ff24 = PIN_W'(chan_flag & fen_v);
    for (int g = 0; g < GRP_N; g++) begin
      grp[g] = |ff24[4*(GRP_N-1-g) +: 4];
    end
  end

  assign ma       = match_a[idx];
  assign mb       = match_b[idx];
  assign ctl      = chan_control[idx];
  assign cnt      = down_count[idx];
  assign ma0      = match_a[0];
  assign mode     = ctl[6:0];
  assign mode0    = chan_control[0][6:0];
  assign fen      = ctl[CTL_FEN_BIT];
  assign off_drv  = ctl[CTL_ODIS_BIT] | output_disable[idx] | channel_disable[idx];
  assign cfg_on   = |(module_control & MOD_GPREN) && !(|(module_control & MOD_MDIS));
  assign last_idx = (idx == IDX_W'(NUM_CHANNELS - 1));
  assign scan_all = (cur_op == OP_TICK) || (cur_op == OP_WR_MOD);
  assign edge_ok  = ctl[CTL_BOTH_BIT] || (ctl[CTL_FALL_BIT] ? !cur_lvl : cur_lvl);

  assign ma_eff  = (ma != '0) ? ma : A_W'(1);
  assign per     = (mode0 == MODE_MCB) ? ((ma0 != '0) ? ma0 : A_W'(1))
                                       : ((mb != '0) ? mb : A_W'(1));
  assign b_c     = (mb > per) ? per : mb;
  assign a_c     = (ma_eff > b_c) ? b_c : ma_eff;
  assign cnt_dec = (cnt != '0) ? cnt - 1'b1 : cnt;

  always_comb begin
    case (duty_phase[idx])
      2'd0:    pwm_d = a_c;
      2'd1:    pwm_d = b_c - a_c;
      default: pwm_d = per - b_c;
    endcase
  end

  assign pre_m     = (PRE_W+1)'(ctl[CH_PRE_LSB +: PRE_W]) + 1'b1;
  assign gpre_m    = GM_W'(module_control[MOD_GPRE_LSB +: GPRE_W]) + 1'b1;
  assign prod_full = (PROD_W+GM_W)'(prod1) * (PROD_W+GM_W)'(gpre_m);
  assign reload    = (prod_full[DATA_W-1:0] != '0) ? prod_full[DATA_W-1:0] : DATA_W'(1);

  assign pop = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      idx             <= '0;
      cur_op          <= OP_NONE;
      out_valid       <= 1'b0;
      count_running   <= '0;
      chan_flag       <= '0;
      pin_out         <= '0;
      pin_in          <= '0;
      chan_irq        <= '0;
      module_control  <= MOD_MDIS;
      output_disable  <= '0;
      channel_disable <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        match_a[i]      <= '0;
        match_b[i]      <= '0;
        alt_a[i]        <= '0;
        chan_control[i] <= '0;
        down_count[i]   <= '0;
        duty_phase[i]   <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur_op   <= q_head.op;
            cur_data <= q_head.data;
            cur_lvl  <= q_head.lvl;
            idx      <= q_head.ch[IDX_W-1:0];
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rd_hold <= '0;
          state   <= ST_DONE;
          case (cur_op)
            OP_RD_A:    rd_hold <= DATA_W'(ma);
            OP_RD_B:    rd_hold <= DATA_W'(mb);
            OP_RD_CNT:  rd_hold <= cnt;
            OP_RD_CTL:  rd_hold <= ctl;
            OP_RD_FLG:  rd_hold <= DATA_W'(chan_flag[idx]);
            OP_RD_ALT:  rd_hold <= DATA_W'(alt_a[idx]);
            OP_RD_MOD:  rd_hold <= module_control;
            OP_RD_ODIS: rd_hold <= output_disable;
            OP_RD_CDIS: rd_hold <= channel_disable;
            OP_WR_A: begin
              match_a[idx] <= cur_data[A_W-1:0];
              state        <= ST_SCAN;
            end
            OP_WR_B:   match_b[idx] <= cur_data[A_W-1:0];
            OP_WR_CTL: begin
              chan_control[idx] <= cur_data;
              if (!cur_data[CTL_FEN_BIT]) chan_irq[idx] <= 1'b0;
              state <= ST_SCAN;
            end
            OP_WR_FLG: begin
              if (cur_data[0]) chan_flag[idx] <= 1'b0;
              chan_irq[idx] <= 1'b0;
            end
            OP_WR_ALT: alt_a[idx] <= cur_data[A_W-1:0];
            OP_WR_MOD: begin
              module_control <= cur_data;
              idx            <= '0;
              state          <= ST_SCAN;
            end
            OP_WR_ODIS: begin
              output_disable <= cur_data;
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                pin_out[i] <= pin_out[i] & ~(odis_v[i] | cur_data[i] | channel_disable[i]);
              end
            end
            OP_WR_CDIS: channel_disable <= cur_data;
            OP_TICK: begin
              idx   <= '0;
              state <= ST_SCAN;
            end
            OP_PIN: begin
              pin_in[idx] <= cur_lvl;
              if (mode == MODE_SAIC && pin_in[idx] != cur_lvl && edge_ok) begin
                match_a[idx]   <= (mode0 == MODE_MCB) ? down_count[0][A_W-1:0] : '0;
                chan_flag[idx] <= 1'b1;
                chan_irq[idx]  <= fen;
              end
            end
            default: rd_hold <= '0;
          endcase
        end
        ST_SCAN: begin
          if (scan_all && !last_idx) begin
            idx <= idx + 1'b1;
          end else begin
            state <= ST_DONE;
          end
          if (cur_op == OP_TICK) begin
            if (count_running[idx]) begin
              down_count[idx] <= cnt_dec;
              if (cnt_dec == '0) begin
                count_running[idx] <= 1'b0;
                if (mode == MODE_OPWMB) begin
                  down_count[idx]    <= (pwm_d != '0) ? DATA_W'(pwm_d) : DATA_W'(1);
                  count_running[idx] <= 1'b1;
                  case (duty_phase[idx])
                    2'd0: begin
                      pin_out[idx]    <= 1'b0;
                      duty_phase[idx] <= 2'd1;
                    end
                    2'd1: begin
                      pin_out[idx]    <= !off_drv;
                      duty_phase[idx] <= 2'd2;
                    end
                    default: begin
                      pin_out[idx]    <= 1'b0;
                      duty_phase[idx] <= 2'd0;
                      chan_flag[idx]  <= 1'b1;
                      chan_irq[idx]   <= fen;
                    end
                  endcase
                end else if (mode == MODE_MCB || mode == MODE_OPWMCB) begin
                  chan_flag[idx] <= 1'b1;
                  chan_irq[idx]  <= fen;
                  pin_out[idx]   <= !off_drv && !pin_out[idx];
                  idx            <= idx;
                  state          <= ST_MUL1;
                end
              end
            end
          end else begin
            if (cfg_on) begin
              idx   <= idx;
              state <= ST_MUL1;
            end else begin
              count_running[idx] <= 1'b0;
            end
          end
        end
        ST_MUL1: begin
          prod1 <= PROD_W'(ma_eff) * PROD_W'(pre_m);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          down_count[idx]    <= reload;
          count_running[idx] <= 1'b1;
          if (scan_all && !last_idx) begin
            idx   <= idx + 1'b1;
            state <= ST_SCAN;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            rdata        <= rd_hold;
            pwm_pins     <= PIN_W'(pin_out);
            channel_irqs <= PIN_W'(chan_irq);
            group_irqs   <= grp;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count_running[idx] |-> (down_count[idx] != '0))
    else $error("running counter holds zero");
  assert property (@(posedge clk) disable iff (rst) duty_phase[idx] != 2'd3)
    else $error("pwm phase out of range");
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result beat issued outside completion");

endmodule

@@ design/multichannel_pwm_capture_timer_core.sv @@
`timescale 1ns / 1ps
// Multi-channel timer, PWM and input-capture block on a 32-bit register map.
// Each input beat (register read, register write, module clock tick or pin
// level change) yields exactly one result beat with read data and the pin and
// interrupt lines as they stand after that beat. Input beats are classified
// and held in a two-entry queue, so the input side keeps accepting while the
// engine works until the queue is full. The engine walks channels one by one:
// reads and plain writes pass the execute and done states; writes to A or
// control also pass the scan state, and the prescale multiply states when the
// counter reloads; a tick or module-control write scans every channel, with
// the multiply states for each channel whose counter is reloaded.
module multichannel_pwm_capture_timer_core #(
  parameter int NUM_CHANNELS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [mpct_pkg::OFF_W-1:0]  offset,
  input  logic [mpct_pkg::DATA_W-1:0] wdata,
  input  logic [mpct_pkg::CH_W-1:0]   pin_channel,
  input  logic                        pin_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mpct_pkg::DATA_W-1:0] rdata,
  output logic [mpct_pkg::PIN_W-1:0]  pwm_pins,
  output logic [mpct_pkg::PIN_W-1:0]  channel_irqs,
  output logic [mpct_pkg::GRP_N-1:0]  group_irqs
);
  import mpct_pkg::*;

  item_t push_item;
  item_t head;
  logic  push, full, pop, empty;

  mpct_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .offset      (offset),
    .wdata       (wdata),
    .pin_channel (pin_channel),
    .pin_level   (pin_level),
    .q_full      (full),
    .push        (push),
    .item        (push_item)
  );

  mpct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  mpct_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (empty),
    .q_head       (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rdata        (rdata),
    .pwm_pins     (pwm_pins),
    .channel_irqs (channel_irqs),
    .group_irqs   (group_irqs)
  );

endmodule
